// ===== design/ghp_pkg.sv =====
// Package for the generational handle pool: sizes, operation and status codes,
// payload structs and memory port structs. Depends on nothing.
package ghp_pkg;

	localparam int CAPACITY = 1024;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int IDX_W    = 16;
	localparam int KEY_W    = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);
	localparam logic [IDX_W-1:0] NO_LINK = '1;

	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    key_out;
		logic [IDX_W-1:0]    index_out;
		logic [IDX_W-1:0]    live_count;
	} ghp_rsp_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic [SLOT_W-1:0] raddr;
	} key_port_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [IDX_W-1:0]  wdata;
		logic [SLOT_W-1:0] raddr;
	} link_port_t;

	function automatic logic is_slot(input logic [IDX_W-1:0] idx);
		return idx < CAP_IDX;
	endfunction

endpackage

// ===== design/ghp_req_if.sv =====
// Request channel of the handle pool: valid/ready handshake and the request fields.
// Depends on ghp_pkg.
interface ghp_req_if import ghp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  handle_key;
	logic [IDX_W-1:0]  handle_index;

	modport source(output valid, kind, handle_key, handle_index, input ready);
	modport sink(input valid, kind, handle_key, handle_index, output ready);
endinterface

// ===== design/ghp_rsp_if.sv =====
// Response channel of the handle pool: valid/ready handshake and the result fields.
// Depends on ghp_pkg.
interface ghp_rsp_if import ghp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    key_out;
	logic [IDX_W-1:0]    index_out;
	logic [IDX_W-1:0]    live_count;

	modport source(output valid, status, key_out, index_out, live_count, input ready);
	modport sink(input valid, status, key_out, index_out, live_count, output ready);
endinterface

// ===== design/generational_handle_pool_core.sv =====
// Top level of the generational handle pool: slot memories, sequencer and result register.
// Depends on ghp_pkg, ghp_req_if, ghp_rsp_if, ghp_ram and ghp_ctrl.
//
//   channel  modport  fields
//   req      sink     kind, handle_key, handle_index
//   rsp      source   status, key_out, index_out, live_count
//
// One request is in flight at a time. A lookup or a rejected request goes through EXEC and
// DONE to the result register; a successful allocate or free also goes through WR2 between
// them, set by the single write port of each slot memory. The next request is accepted in
// IDLE, after the result has left DONE. Reset clears the heads and counters at once; the key
// memory is not reset, since slots at or above the fresh-slot mark read as free.
// A result waiting in the output register does not block acceptance of the next request.
module generational_handle_pool_core import ghp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ghp_req_if.sink   req,
	ghp_rsp_if.source rsp
);
	key_port_t        key_port;
	link_port_t       next_port;
	link_port_t       prev_port;
	logic [KEY_W-1:0] key_rdata;
	logic [IDX_W-1:0] next_rdata;
	logic [IDX_W-1:0] prev_rdata;
	logic             res_valid;
	logic             res_take;
	ghp_rsp_t         res;
	ghp_rsp_t         rsp_q;
	logic             rsp_valid_q;

	ghp_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (key_port.we),
		.waddr (key_port.waddr),
		.wdata (key_port.wdata),
		.raddr (key_port.raddr),
		.rdata (key_rdata)
	);

	ghp_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
		.clk   (clk),
		.we    (next_port.we),
		.waddr (next_port.waddr),
		.wdata (next_port.wdata),
		.raddr (next_port.raddr),
		.rdata (next_rdata)
	);

	ghp_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
		.clk   (clk),
		.we    (prev_port.we),
		.waddr (prev_port.waddr),
		.wdata (prev_port.wdata),
		.raddr (prev_port.raddr),
		.rdata (prev_rdata)
	);

	ghp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.key_port   (key_port),
		.next_port  (next_port),
		.prev_port  (prev_port),
		.key_rdata  (key_rdata),
		.next_rdata (next_rdata),
		.prev_rdata (prev_rdata),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take)
	);

	assign res_take = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_q.status;
	assign rsp.key_out    = rsp_q.key_out;
	assign rsp.index_out  = rsp_q.index_out;
	assign rsp.live_count = rsp_q.live_count;
endmodule

// ===== design/ghp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module ghp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/ghp_ctrl.sv =====
// Sequencer of the handle pool: list heads, counters and the read-modify-write
// steps over the key, next and prev memories. Depends on ghp_pkg and ghp_req_if.
module ghp_ctrl import ghp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ghp_req_if.sink          req,
	output key_port_t        key_port,
	output link_port_t       next_port,
	output link_port_t       prev_port,
	input  logic [KEY_W-1:0] key_rdata,
	input  logic [IDX_W-1:0] next_rdata,
	input  logic [IDX_W-1:0] prev_rdata,
	output logic             res_valid,
	output ghp_rsp_t         res,
	input  logic             res_take
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WR2  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]          state_q;
	logic [KIND_W-1:0]   kind_q;
	logic [KEY_W-1:0]    key_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    free_head_q;
	logic [IDX_W-1:0]    used_head_q;
	logic [IDX_W-1:0]    high_water_q;
	logic [KEY_W-1:0]    key_ctr_q;
	logic [IDX_W-1:0]    count_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [KEY_W-1:0]    res_key_q;
	logic [IDX_W-1:0]    res_index_q;

	logic             fh_ok;
	logic             hw_ok;
	logic             full;
	logic             key_ok;
	logic [IDX_W-1:0] alloc_slot;
	logic [KEY_W-1:0] key_ctr_inc;

	assign req.ready = (state_q == S_IDLE);
	assign fh_ok     = is_slot(free_head_q);
	assign hw_ok     = high_water_q < CAP_IDX;
	assign full      = !fh_ok && !hw_ok;
	assign alloc_slot = fh_ok ? free_head_q : high_water_q;
	assign key_ok    = (key_q != '0) && (idx_q < high_water_q) && (key_rdata == key_q);
	assign key_ctr_inc = key_ctr_q + 1'b1;

	assign res_valid = (state_q == S_DONE);
	assign res = '{status: res_status_q, key_out: res_key_q, index_out: res_index_q,
		live_count: count_q};

	always_comb begin
		key_port  = '{we: 1'b0, waddr: idx_q[SLOT_W-1:0], wdata: '0,
			raddr: req.handle_index[SLOT_W-1:0]};
		next_port = '{we: 1'b0, waddr: idx_q[SLOT_W-1:0], wdata: '0,
			raddr: req.handle_index[SLOT_W-1:0]};
		prev_port = '{we: 1'b0, waddr: idx_q[SLOT_W-1:0], wdata: '0,
			raddr: req.handle_index[SLOT_W-1:0]};
		if (req.kind == KIND_ALLOC) begin
			next_port.raddr = free_head_q[SLOT_W-1:0];
		end
		case (state_q)
			S_EXEC: begin
				if (kind_q == KIND_ALLOC && !full) begin
					key_port.we     = 1'b1;
					key_port.waddr  = alloc_slot[SLOT_W-1:0];
					key_port.wdata  = key_ctr_q;
					next_port.we    = 1'b1;
					next_port.waddr = alloc_slot[SLOT_W-1:0];
					next_port.wdata = used_head_q;
					prev_port.we    = is_slot(used_head_q);
					prev_port.waddr = used_head_q[SLOT_W-1:0];
					prev_port.wdata = alloc_slot;
				end else if (kind_q == KIND_FREE && key_ok) begin
					key_port.we     = 1'b1;
					key_port.wdata  = '0;
					next_port.we    = (idx_q != used_head_q) && is_slot(prev_rdata);
					next_port.waddr = prev_rdata[SLOT_W-1:0];
					next_port.wdata = next_rdata;
					prev_port.we    = is_slot(next_rdata);
					prev_port.waddr = next_rdata[SLOT_W-1:0];
					prev_port.wdata = prev_rdata;
				end
			end
			S_WR2: begin
				if (kind_q == KIND_FREE) begin
					next_port.we    = 1'b1;
					next_port.wdata = free_head_q;
				end else begin
					prev_port.we    = 1'b1;
					prev_port.wdata = NO_LINK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_head_q  <= NO_LINK;
			used_head_q  <= NO_LINK;
			high_water_q <= '0;
			key_ctr_q    <= KEY_W'(1);
			count_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (kind_q)
						KIND_ALLOC: begin
							if (!full) begin
								if (fh_ok) begin
									free_head_q <= next_rdata;
								end else begin
									high_water_q <= high_water_q + 1'b1;
								end
								used_head_q <= alloc_slot;
								key_ctr_q   <= (key_ctr_inc == '0) ? KEY_W'(1) : key_ctr_inc;
								count_q     <= count_q + 1'b1;
								state_q     <= S_WR2;
							end
						end
						KIND_FREE: begin
							if (key_ok) begin
								if (idx_q == used_head_q) begin
									used_head_q <= next_rdata;
								end
								count_q <= count_q - 1'b1;
								state_q <= S_WR2;
							end
						end
						default: begin
						end
					endcase
				end
				S_WR2: begin
					if (kind_q == KIND_FREE) begin
						free_head_q <= idx_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			kind_q <= req.kind;
			key_q  <= req.handle_key;
			idx_q  <= req.handle_index;
		end
		if (state_q == S_EXEC) begin
			res_key_q   <= key_q;
			res_index_q <= idx_q;
			case (kind_q)
				KIND_ALLOC: begin
					if (full) begin
						res_status_q <= ST_FULL;
						res_key_q    <= '0;
						res_index_q  <= '0;
					end else begin
						res_status_q <= ST_OK;
						res_key_q    <= key_ctr_q;
						res_index_q  <= alloc_slot;
						idx_q        <= alloc_slot;
					end
				end
				KIND_LOOKUP, KIND_FREE: begin
					res_status_q <= key_ok ? ST_OK : ST_BAD;
				end
				default: begin
					res_status_q <= ST_BAD;
				end
			endcase
		end
	end
endmodule
